[rtl/pcc_pkg.sv]
// Shared widths, reset values, beat types and the helper function of the PID controller.
`timescale 1ns / 1ps

package pcc_pkg;

  // Width of setpoint, measured value and drive (Q16.16 at the default of 32).
  localparam int DATA_WIDTH = 32;

  localparam int GAIN_W     = 24;
  localparam int DT_W       = 24;
  localparam int LIMIT_W    = 31;
  localparam int INTEG_W    = 48;
  localparam int ERR_W      = DATA_WIDTH + 1;
  localparam int DIFF_W     = DATA_WIDTH + 2;

  // Fraction bits of the time step and of the gains.
  localparam int DT_FRAC    = 24;
  localparam int GAIN_FRAC  = 12;

  // The derivative is the quotient of (difference << DT_FRAC) by the time step.
  localparam int QUO_W      = DIFF_W + DT_FRAC;

  // The derivative magnitude is capped at 2^DERIV_BITS - 1, each term at 2^TERM_BITS - 1.
  localparam int DERIV_BITS = 58;
  localparam int TERM_BITS  = 47;
  localparam int SUM_W      = TERM_BITS + 3;

  // Shared shift-and-add multiplier operand widths.
  localparam int MCAND_W    = DERIV_BITS;
  localparam int MPLR_W     = 24;
  localparam int PROD_W     = MCAND_W + MPLR_W;

  localparam int MUL_CNT_W  = $clog2(MPLR_W + 1);
  localparam int DIV_CNT_W  = $clog2(QUO_W + 1);

  localparam int DERIV_CMP_W = (QUO_W > MCAND_W) ? QUO_W : MCAND_W;
  localparam int LIM_CMP_W   = (LIMIT_W > DATA_WIDTH - 1) ? LIMIT_W : DATA_WIDTH - 1;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = LIMIT_W;

  localparam logic [GAIN_W-1:0]  GAIN_PROP_RESET  = GAIN_W'(20480);
  localparam logic [GAIN_W-1:0]  GAIN_INTEG_RESET = GAIN_W'(204800);
  localparam logic [GAIN_W-1:0]  GAIN_DERIV_RESET = GAIN_W'(4096);
  localparam logic [LIMIT_W-1:0] LIMIT_RESET      = LIMIT_W'(335544);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GAIN_PROP,
    CFG_GAIN_INTEG,
    CFG_GAIN_DERIV,
    CFG_EFFORT_LIMIT
  } cfg_idx_t;

  typedef struct packed {
    logic signed [DATA_WIDTH-1:0] setpoint;
    logic signed [DATA_WIDTH-1:0] measured;
    logic        [DT_W-1:0]       step_time;
  } in_beat_t;

  typedef struct packed {
    logic signed [DATA_WIDTH-1:0] drive;
    logic                         clamped;
  } out_beat_t;

  typedef struct packed {
    logic               start;
    logic [MCAND_W-1:0] mcand;
    logic [MPLR_W-1:0]  mplr;
  } mul_req_t;

  typedef struct packed {
    logic              done;
    logic [PROD_W-1:0] prod;
  } mul_rsp_t;

  typedef struct packed {
    logic             start;
    logic [QUO_W-1:0] dividend;
    logic [DT_W-1:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic             busy;
    logic [QUO_W-1:0] quo;
  } div_rsp_t;

  // Limit in effect: the programmed limit, but no more than the largest drive value.
  function automatic logic [DATA_WIDTH-2:0] eff_limit(input logic [LIMIT_W-1:0] limit);
    logic [LIM_CMP_W-1:0] l;
    logic [LIM_CMP_W-1:0] w;
    l = LIM_CMP_W'(limit);
    w = LIM_CMP_W'({(DATA_WIDTH - 1){1'b1}});
    return (l < w) ? l[DATA_WIDTH-2:0] : w[DATA_WIDTH-2:0];
  endfunction

endpackage

[rtl/pcc_mul.sv]
// Radix-2 shift-and-add multiplier, one multiplier bit per cycle.
`timescale 1ns / 1ps

module pcc_mul import pcc_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  mul_req_t req,
  output mul_rsp_t rsp
);

  logic [MCAND_W-1:0]   mcand_r;
  logic [MCAND_W-1:0]   hi_r, hi_nxt;
  logic [MPLR_W-1:0]    lo_r, lo_nxt;
  logic [MUL_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic [MCAND_W:0]     psum;

  // The multiplier bits leave the low end of lo_r while product bits enter its top.
  always_comb begin
    psum     = {1'b0, hi_r} + (lo_r[0] ? {1'b0, mcand_r} : {(MCAND_W + 1){1'b0}});
    hi_nxt   = hi_r;
    lo_nxt   = lo_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (req.start) begin
      hi_nxt   = '0;
      lo_nxt   = req.mplr;
      cnt_nxt  = MUL_CNT_W'(MPLR_W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      hi_nxt  = psum[MCAND_W:1];
      lo_nxt  = {psum[0], lo_r[MPLR_W-1:1]};
      cnt_nxt = cnt_r - MUL_CNT_W'(1);
      if (cnt_r == MUL_CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    hi_r <= hi_nxt;
    lo_r <= lo_nxt;
    if (req.start) begin
      mcand_r <= req.mcand;
    end
  end

  assign rsp.done = done_r;
  assign rsp.prod = {hi_r, lo_r};

endmodule

[rtl/pcc_div.sv]
// Restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps

module pcc_div import pcc_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic [QUO_W-1:0]     q_r, q_nxt;
  logic [DT_W-1:0]      rem_r, rem_nxt;
  logic [DT_W-1:0]      dvs_r;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                 busy_r, busy_nxt;
  logic [DT_W:0]        trial;
  logic [DT_W:0]        diff;
  logic                 ge;

  // Dividend bits shift out of the top of q_r as quotient bits shift in at the bottom.
  always_comb begin
    trial    = {rem_r, q_r[QUO_W-1]};
    diff     = trial - {1'b0, dvs_r};
    ge       = (trial >= {1'b0, dvs_r});
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    if (req.start) begin
      q_nxt    = req.dividend;
      rem_nxt  = '0;
      cnt_nxt  = DIV_CNT_W'(QUO_W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      q_nxt   = {q_r[QUO_W-2:0], ge};
      rem_nxt = ge ? diff[DT_W-1:0] : trial[DT_W-1:0];
      cnt_nxt = cnt_r - DIV_CNT_W'(1);
      if (cnt_r == DIV_CNT_W'(1)) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    if (req.start) begin
      dvs_r <= req.divisor;
    end
  end

  assign rsp.busy = busy_r;
  assign rsp.quo  = q_r;

endmodule

[rtl/pid_controller_with_clamp_top.sv]
// Top level of the PID controller with output clamp: sequencer, state and configuration.
`timescale 1ns / 1ps

// PID controller with a symmetric output clamp. Each input beat carries a setpoint and a
// measured value (signed Q16.16) and the time step since the previous beat (unsigned Q0.24
// seconds). The block forms error = setpoint - measured, adds error * dt into a saturating
// 48-bit Q32.16 integral, takes the derivative (error - previous error) / dt, and returns
// drive = Kp * error + Ki * integral + Kd * derivative clamped to plus or minus the effort
// limit, with a flag that is set when the clamp acted. A zero time step gives a zero
// derivative term. Products and the quotient round toward zero, and each weighted term
// saturates at +/-(2^47 - 1) before the sum. Gains are signed Q12.12 and are written through
// the cfg port (index 0 proportional, 1 integral, 2 derivative, 3 effort limit); write them
// only while no beat is in flight. The block works on one beat at a time and takes no
// new beat until its sequencer is back at idle. The four products go one after another
// through a single shift-and-add multiplier that retires one multiplier bit per cycle,
// while the restoring divider for the derivative runs alongside the first three. The
// result waits in an output register, so the next input beat is taken as soon as the
// sequencer is back at idle, even while the previous result has not yet been taken.
module pid_controller_with_clamp_top import pcc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_beat_t              in_beat,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_beat_t             out_beat,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int INCW_W = PROD_W - DT_FRAC;
  localparam logic [INCW_W-1:0] INC_CAP = INCW_W'(1) << (INTEG_W - 1);
  localparam logic [DERIV_CMP_W-1:0] DERIV_CAP = DERIV_CMP_W'({DERIV_BITS{1'b1}});

  typedef enum logic [3:0] {
    S_IDLE,
    S_PREP,
    S_LAUNCH,
    S_INC,
    S_ACC,
    S_IMAG,
    S_PMUL,
    S_IMUL,
    S_DWAIT,
    S_DMUL,
    S_SUM1,
    S_SUM2,
    S_CLAMP
  } state_t;

  // Magnitude of a signed gain; the most negative gain maps to 2^23.
  function automatic logic [MPLR_W-1:0] gain_mag(input logic [GAIN_W-1:0] g);
    return MPLR_W'(g[GAIN_W-1] ? (GAIN_W'(0) - g) : g);
  endfunction

  // Weighted term from a raw product: drop the gain fraction, saturate, apply the sign.
  function automatic logic [SUM_W-1:0] term_of(input logic [PROD_W-1:0] p, input logic neg);
    logic [TERM_BITS-1:0] m;
    logic [SUM_W-1:0]     e;
    if (|p[PROD_W-1:GAIN_FRAC+TERM_BITS]) begin
      m = '1;
    end else begin
      m = p[GAIN_FRAC+TERM_BITS-1:GAIN_FRAC];
    end
    e = SUM_W'(m);
    return neg ? (SUM_W'(0) - e) : e;
  endfunction

  // Configuration registers.
  logic [GAIN_W-1:0]  gain_prop_r;
  logic [GAIN_W-1:0]  gain_integ_r;
  logic [GAIN_W-1:0]  gain_deriv_r;
  logic [LIMIT_W-1:0] effort_limit_r;

  // Control state, controller state and the output register.
  state_t             state_r, state_nxt;
  logic               out_valid_r, out_valid_nxt;
  out_beat_t          out_beat_r, out_beat_nxt;
  logic [INTEG_W-1:0] integ_r, integ_nxt;
  logic [ERR_W-1:0]   last_err_r, last_err_nxt;
  logic               mul_start_r, mul_start_nxt;
  logic               div_start_r, div_start_nxt;

  // Working registers of the beat in flight.
  logic [ERR_W-1:0]        err_r, err_nxt;
  logic [ERR_W-1:0]        err_mag_r, err_mag_nxt;
  logic [DIFF_W-1:0]       diff_r, diff_nxt;
  logic [DT_W-1:0]         dt_r, dt_nxt;
  logic [INTEG_W-1:0]      inc_mag_r, inc_mag_nxt;
  logic [INTEG_W-1:0]      integ_mag_r, integ_mag_nxt;
  logic [SUM_W-1:0]        pterm_r, pterm_nxt;
  logic [SUM_W-1:0]        iterm_r, iterm_nxt;
  logic [SUM_W-1:0]        dterm_r, dterm_nxt;
  logic [SUM_W-1:0]        sum_r, sum_nxt;
  logic [DATA_WIDTH-2:0]   lim_r, lim_nxt;
  logic                    term_neg_r, term_neg_nxt;
  logic [MCAND_W-1:0]      mul_mcand_r, mul_mcand_nxt;
  logic [MPLR_W-1:0]       mul_mplr_r, mul_mplr_nxt;
  logic [QUO_W-1:0]        div_dividend_r, div_dividend_nxt;

  // Combinational helpers.
  logic [ERR_W-1:0]        sp_ext, ms_ext;
  logic [DIFF_W-1:0]       diff_mag;
  logic [INCW_W-1:0]       incw;
  logic [INTEG_W:0]        acc;
  logic [DERIV_CMP_W-1:0]  deriv_ext;
  logic [MCAND_W-1:0]      deriv_mag;
  logic [SUM_W:0]          low_chk;
  logic                    over_hi, over_lo;

  mul_req_t mul_req;
  mul_rsp_t mul_rsp;
  div_req_t div_req;
  div_rsp_t div_rsp;

  pcc_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mul_req),
    .rsp   (mul_rsp)
  );

  pcc_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  assign mul_req.start    = mul_start_r;
  assign mul_req.mcand    = mul_mcand_r;
  assign mul_req.mplr     = mul_mplr_r;
  assign div_req.start    = div_start_r;
  assign div_req.dividend = div_dividend_r;
  assign div_req.divisor  = dt_r;

  // Register writes. The index field is two bits wide, so every index names a register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_prop_r    <= GAIN_PROP_RESET;
      gain_integ_r   <= GAIN_INTEG_RESET;
      gain_deriv_r   <= GAIN_DERIV_RESET;
      effort_limit_r <= LIMIT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_idx))
        CFG_GAIN_PROP:    gain_prop_r    <= cfg_data[GAIN_W-1:0];
        CFG_GAIN_INTEG:   gain_integ_r   <= cfg_data[GAIN_W-1:0];
        CFG_GAIN_DERIV:   gain_deriv_r   <= cfg_data[GAIN_W-1:0];
        CFG_EFFORT_LIMIT: effort_limit_r <= cfg_data[LIMIT_W-1:0];
      endcase
    end
  end

  always_comb begin
    // Datapath pieces that the sequencer picks from.
    sp_ext    = {in_beat.setpoint[DATA_WIDTH-1], in_beat.setpoint};
    ms_ext    = {in_beat.measured[DATA_WIDTH-1], in_beat.measured};
    diff_mag  = diff_r[DIFF_W-1] ? (DIFF_W'(0) - diff_r) : diff_r;
    incw      = mul_rsp.prod[PROD_W-1:DT_FRAC];
    acc       = term_neg_r ? ({integ_r[INTEG_W-1], integ_r} - {1'b0, inc_mag_r})
                           : ({integ_r[INTEG_W-1], integ_r} + {1'b0, inc_mag_r});
    deriv_ext = DERIV_CMP_W'(div_rsp.quo);
    if (dt_r == '0) begin
      deriv_mag = '0;
    end else if (deriv_ext > DERIV_CAP) begin
      deriv_mag = DERIV_CAP[MCAND_W-1:0];
    end else begin
      deriv_mag = deriv_ext[MCAND_W-1:0];
    end
    over_hi = $signed(sum_r) > $signed(SUM_W'(lim_r));
    low_chk = {sum_r[SUM_W-1], sum_r} + (SUM_W + 1)'(lim_r);
    over_lo = low_chk[SUM_W];

    // Defaults: everything holds, start strobes drop.
    state_nxt        = state_r;
    out_valid_nxt    = out_valid_r;
    out_beat_nxt     = out_beat_r;
    integ_nxt        = integ_r;
    last_err_nxt     = last_err_r;
    mul_start_nxt    = 1'b0;
    div_start_nxt    = 1'b0;
    err_nxt          = err_r;
    err_mag_nxt      = err_mag_r;
    diff_nxt         = diff_r;
    dt_nxt           = dt_r;
    inc_mag_nxt      = inc_mag_r;
    integ_mag_nxt    = integ_mag_r;
    pterm_nxt        = pterm_r;
    iterm_nxt        = iterm_r;
    dterm_nxt        = dterm_r;
    sum_nxt          = sum_r;
    lim_nxt          = lim_r;
    term_neg_nxt     = term_neg_r;
    mul_mcand_nxt    = mul_mcand_r;
    mul_mplr_nxt     = mul_mplr_r;
    div_dividend_nxt = div_dividend_r;

    // The consumer takes the waiting result.
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          err_nxt   = sp_ext - ms_ext;
          dt_nxt    = in_beat.step_time;
          state_nxt = S_PREP;
        end
      end
      S_PREP: begin
        // The difference uses the error of the previous beat, then the new error is kept.
        err_mag_nxt  = err_r[ERR_W-1] ? (ERR_W'(0) - err_r) : err_r;
        diff_nxt     = {err_r[ERR_W-1], err_r} - {last_err_r[ERR_W-1], last_err_r};
        last_err_nxt = err_r;
        state_nxt    = S_LAUNCH;
      end
      S_LAUNCH: begin
        div_dividend_nxt = {diff_mag, {DT_FRAC{1'b0}}};
        div_start_nxt    = 1'b1;
        mul_mcand_nxt    = MCAND_W'(err_mag_r);
        mul_mplr_nxt     = MPLR_W'(dt_r);
        mul_start_nxt    = 1'b1;
        term_neg_nxt     = err_r[ERR_W-1];
        state_nxt        = S_INC;
      end
      S_INC: begin
        if (mul_rsp.done) begin
          inc_mag_nxt   = (incw > INC_CAP) ? INTEG_W'(INC_CAP) : incw[INTEG_W-1:0];
          mul_mcand_nxt = MCAND_W'(err_mag_r);
          mul_mplr_nxt  = gain_mag(gain_prop_r);
          mul_start_nxt = 1'b1;
          state_nxt     = S_ACC;
        end
      end
      S_ACC: begin
        // Saturating integral update; term_neg_r still holds the sign of the error.
        if (acc[INTEG_W] != acc[INTEG_W-1]) begin
          integ_nxt = acc[INTEG_W] ? {1'b1, {(INTEG_W - 1){1'b0}}}
                                   : {1'b0, {(INTEG_W - 1){1'b1}}};
        end else begin
          integ_nxt = acc[INTEG_W-1:0];
        end
        term_neg_nxt = err_r[ERR_W-1] ^ gain_prop_r[GAIN_W-1];
        state_nxt    = S_IMAG;
      end
      S_IMAG: begin
        integ_mag_nxt = integ_r[INTEG_W-1] ? (INTEG_W'(0) - integ_r) : integ_r;
        state_nxt     = S_PMUL;
      end
      S_PMUL: begin
        if (mul_rsp.done) begin
          pterm_nxt     = term_of(mul_rsp.prod, term_neg_r);
          mul_mcand_nxt = MCAND_W'(integ_mag_r);
          mul_mplr_nxt  = gain_mag(gain_integ_r);
          mul_start_nxt = 1'b1;
          term_neg_nxt  = integ_r[INTEG_W-1] ^ gain_integ_r[GAIN_W-1];
          state_nxt     = S_IMUL;
        end
      end
      S_IMUL: begin
        if (mul_rsp.done) begin
          iterm_nxt = term_of(mul_rsp.prod, term_neg_r);
          state_nxt = S_DWAIT;
        end
      end
      S_DWAIT: begin
        if (!div_rsp.busy) begin
          mul_mcand_nxt = deriv_mag;
          mul_mplr_nxt  = gain_mag(gain_deriv_r);
          mul_start_nxt = 1'b1;
          term_neg_nxt  = diff_r[DIFF_W-1] ^ gain_deriv_r[GAIN_W-1];
          state_nxt     = S_DMUL;
        end
      end
      S_DMUL: begin
        if (mul_rsp.done) begin
          dterm_nxt = term_of(mul_rsp.prod, term_neg_r);
          state_nxt = S_SUM1;
        end
      end
      S_SUM1: begin
        sum_nxt   = pterm_r + iterm_r;
        lim_nxt   = eff_limit(effort_limit_r);
        state_nxt = S_SUM2;
      end
      S_SUM2: begin
        sum_nxt   = sum_r + dterm_r;
        state_nxt = S_CLAMP;
      end
      S_CLAMP: begin
        // Wait here only while an earlier result still sits unread in the output register.
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          if (over_hi) begin
            out_beat_nxt.drive   = DATA_WIDTH'(lim_r);
            out_beat_nxt.clamped = 1'b1;
          end else if (over_lo) begin
            out_beat_nxt.drive   = DATA_WIDTH'(0) - DATA_WIDTH'(lim_r);
            out_beat_nxt.clamped = 1'b1;
          end else begin
            out_beat_nxt.drive   = sum_r[DATA_WIDTH-1:0];
            out_beat_nxt.clamped = 1'b0;
          end
          state_nxt = S_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      out_beat_r  <= '0;
      integ_r     <= '0;
      last_err_r  <= '0;
      mul_start_r <= 1'b0;
      div_start_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      out_beat_r  <= out_beat_nxt;
      integ_r     <= integ_nxt;
      last_err_r  <= last_err_nxt;
      mul_start_r <= mul_start_nxt;
      div_start_r <= div_start_nxt;
    end
  end

  always_ff @(posedge clk) begin
    err_r          <= err_nxt;
    err_mag_r      <= err_mag_nxt;
    diff_r         <= diff_nxt;
    dt_r           <= dt_nxt;
    inc_mag_r      <= inc_mag_nxt;
    integ_mag_r    <= integ_mag_nxt;
    pterm_r        <= pterm_nxt;
    iterm_r        <= iterm_nxt;
    dterm_r        <= dterm_nxt;
    sum_r          <= sum_nxt;
    lim_r          <= lim_nxt;
    term_neg_r     <= term_neg_nxt;
    mul_mcand_r    <= mul_mcand_nxt;
    mul_mplr_r     <= mul_mplr_nxt;
    div_dividend_r <= div_dividend_nxt;
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_beat  = out_beat_r;

endmodule

[rtl/pcc_checker.sv]
// Port-level assertions for the PID controller top level, with the bind that attaches them.
`timescale 1ns / 1ps

module pcc_checker import pcc_pkg::*; (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_valid,
  input logic                  in_ready,
  input logic                  out_valid,
  input logic                  out_ready,
  input out_beat_t             out_beat,
  input logic                  cfg_we,
  input logic [CFG_IDX_W-1:0]  cfg_idx,
  input logic [CFG_DATA_W-1:0] cfg_data
);

  logic [LIMIT_W-1:0]          limit_r;
  logic signed [DATA_WIDTH:0]  lim_s;
  logic signed [DATA_WIDTH:0]  drive_s;

  // Shadow of the effort limit as seen on the configuration port.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= LIMIT_RESET;
    end else if (cfg_we && (cfg_idx_t'(cfg_idx) == CFG_EFFORT_LIMIT)) begin
      limit_r <= cfg_data[LIMIT_W-1:0];
    end
  end

  assign lim_s   = $signed({2'b00, eff_limit(limit_r)});
  assign drive_s = $signed({out_beat.drive[DATA_WIDTH-1], out_beat.drive});

  // An accepted beat keeps the block busy for at least the next cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input still ready right after an accepted beat");

  // A new result only appears at the end of work on a beat.
  a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result appeared while the block was idle");

  // A clamped drive sits exactly on one of the two limits.
  a_clamp_on_limit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_beat.clamped |-> (drive_s == lim_s) || (drive_s == -lim_s))
    else $error("clamped drive not on the effort limit");

  // An unclamped drive lies within the limits.
  a_within_limit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_beat.clamped |-> (drive_s <= lim_s) && (drive_s >= -lim_s))
    else $error("unclamped drive beyond the effort limit");

  // A waiting result holds until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_beat))
    else $error("result dropped or changed while stalled");

endmodule

bind pid_controller_with_clamp_top pcc_checker u_pcc_checker (.*);

[dv/testbench.sv]
// Self-checking testbench for the PID controller with output clamp.
`timescale 1ns / 1ps

import pcc_pkg::*;

// Bounds used by the bit-true prediction of one controller update.
localparam longint INTEG_HI  = (longint'(1) << (INTEG_W - 1)) - 1;
localparam longint INTEG_LO  = -(longint'(1) << (INTEG_W - 1));
localparam longint TERM_CAP  = (longint'(1) << TERM_BITS) - 1;
localparam longint DERIV_CAP = (longint'(1) << DERIV_BITS) - 1;
localparam longint DRIVE_HI  = (longint'(1) << (DATA_WIDTH - 1)) - 1;

// Mirrors the controller state and registers, predicts each drive beat and checks
// the beats that come back in order.
class drive_tracker;
  logic signed [GAIN_W-1:0] kp;
  logic signed [GAIN_W-1:0] ki;
  logic signed [GAIN_W-1:0] kd;
  logic [LIMIT_W-1:0]       limit;
  longint                   integ;
  longint                   prev_err;
  out_beat_t                awaited[$];
  int unsigned              mismatches;

  function new();
    kp         = GAIN_PROP_RESET;
    ki         = GAIN_INTEG_RESET;
    kd         = GAIN_DERIV_RESET;
    limit      = LIMIT_RESET;
    integ      = 0;
    prev_err   = 0;
    mismatches = 0;
  endfunction

  function void write_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] data);
    case (idx)
      CFG_GAIN_PROP:    kp = data[GAIN_W-1:0];
      CFG_GAIN_INTEG:   ki = data[GAIN_W-1:0];
      CFG_GAIN_DERIV:   kd = data[GAIN_W-1:0];
      CFG_EFFORT_LIMIT: limit = data[LIMIT_W-1:0];
      default: ;
    endcase
  endfunction

  // Product shifted right, rounded toward zero on the magnitude and capped.
  function longint scale_sat(longint x, longint y, int unsigned sh, longint cap);
    logic [127:0] ax;
    logic [127:0] ay;
    logic [127:0] prod;
    longint       mag_r;
    ax = 128'(x < 0 ? -x : x);
    ay = 128'(y < 0 ? -y : y);
    prod = (ax * ay) >> sh;
    if (prod > 128'(cap)) prod = 128'(cap);
    mag_r = longint'(prod[63:0]);
    return ((x < 0) != (y < 0)) ? -mag_r : mag_r;
  endfunction

  function void take_sample(in_beat_t b);
    longint       err;
    longint       acc;
    longint       diff;
    longint       rate;
    longint       p_term;
    longint       i_term;
    longint       d_term;
    longint       sum;
    longint       lim;
    logic [127:0] dmag;
    logic         clip;
    out_beat_t    want;
    err = longint'($signed(b.setpoint)) - longint'($signed(b.measured));
    acc = integ + scale_sat(err, longint'(b.step_time), DT_FRAC, longint'(1) << (INTEG_W - 1));
    if (acc > INTEG_HI) acc = INTEG_HI;
    else if (acc < INTEG_LO) acc = INTEG_LO;
    integ = acc;
    diff = err - prev_err;
    if (b.step_time == '0) begin
      rate = 0;
    end else begin
      dmag = 128'(diff < 0 ? -diff : diff);
      dmag = (dmag << DT_FRAC) / 128'(b.step_time);
      if (dmag > 128'(DERIV_CAP)) dmag = 128'(DERIV_CAP);
      rate = (diff < 0) ? -longint'(dmag[63:0]) : longint'(dmag[63:0]);
    end
    p_term = scale_sat(err, longint'(kp), GAIN_FRAC, TERM_CAP);
    i_term = scale_sat(integ, longint'(ki), GAIN_FRAC, TERM_CAP);
    d_term = scale_sat(rate, longint'(kd), GAIN_FRAC, TERM_CAP);
    sum = p_term + i_term + d_term;
    lim = longint'(limit);
    if (lim > DRIVE_HI) lim = DRIVE_HI;
    clip = 1'b0;
    if (sum > lim) begin
      sum  = lim;
      clip = 1'b1;
    end else if (sum < -lim) begin
      sum  = -lim;
      clip = 1'b1;
    end
    prev_err     = err;
    want.drive   = sum[DATA_WIDTH-1:0];
    want.clamped = clip;
    awaited.push_back(want);
  endfunction

  function void compare_drive(out_beat_t got);
    out_beat_t want;
    if (awaited.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("unexpected drive beat: drive %0d clamped %0b", $signed(got.drive), got.clamped);
      return;
    end
    want = awaited.pop_front();
    if (got.drive !== want.drive || got.clamped !== want.clamped) begin
      mismatches++;
      if (mismatches <= 10)
        $display("drive mismatch: expected drive %0d clamped %0b, got drive %0d clamped %0b",
                 $signed(want.drive), want.clamped, $signed(got.drive), got.clamped);
    end
  endfunction

  function int unsigned outstanding();
    return awaited.size();
  endfunction
endclass

module testbench;

  // Corner values of the beat fields and the registers.
  localparam logic signed [DATA_WIDTH-1:0] VAL_MAX = {1'b0, {(DATA_WIDTH - 1){1'b1}}};
  localparam logic signed [DATA_WIDTH-1:0] VAL_MIN = {1'b1, {(DATA_WIDTH - 1){1'b0}}};
  localparam logic signed [DATA_WIDTH-1:0] VAL_ONE = DATA_WIDTH'(1 << 16);
  localparam logic [DT_W-1:0]     DT_MAX    = '1;
  localparam logic [DT_W-1:0]     DT_10MS   = DT_W'(167772);
  localparam logic [GAIN_W-1:0]   GAIN_MAX  = {1'b0, {(GAIN_W - 1){1'b1}}};
  localparam logic [GAIN_W-1:0]   GAIN_MIN  = {1'b1, {(GAIN_W - 1){1'b0}}};
  localparam logic [GAIN_W-1:0]   GAIN_ONE  = GAIN_W'(1 << GAIN_FRAC);
  localparam logic [LIMIT_W-1:0]  LIMIT_MAX = '1;
  localparam int                  PAD_W     = CFG_DATA_W - GAIN_W;
  localparam int                  GAP_MAX   = 17;
  // The receiver stalls this long twice so that the result register fills and
  // the block stops taking new beats while the sender keeps offering.
  localparam int                  HOLD_OFF  = 600;
  // Wait that covers the tail of the run.
  localparam int                  TAIL      = 150;

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_ready;
  in_beat_t              in_beat;
  logic                  out_valid;
  logic                  out_ready;
  out_beat_t             out_beat;
  logic                  cfg_we;
  cfg_idx_t              cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_data;

  drive_tracker tracker;
  int unsigned  beats_sent;
  int unsigned  beats_returned;
  // Set during the integral ramp so that both sides run without gaps.
  bit           ramp_on;

  pid_controller_with_clamp_top uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_beat   (in_beat),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_beat  (out_beat),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic in_beat_t make_beat(logic signed [DATA_WIDTH-1:0] sp,
                                         logic signed [DATA_WIDTH-1:0] ms,
                                         logic [DT_W-1:0] dt);
    in_beat_t b;
    b.setpoint  = sp;
    b.measured  = ms;
    b.step_time = dt;
    return b;
  endfunction

  function automatic logic signed [DATA_WIDTH-1:0] corner_value();
    case ($urandom_range(4, 0))
      0: return VAL_MIN;
      1: return VAL_MAX;
      2: return '0;
      3: return '1;
      default: return DATA_WIDTH'(1);
    endcase
  endfunction

  // Most beats look like a loop in closed operation: a setpoint near the measured
  // value and a small time step that is now and then zero. The rest are unconstrained
  // values and corners.
  function automatic in_beat_t random_beat();
    in_beat_t    b;
    int unsigned pick;
    int          target;
    pick = $urandom_range(99, 0);
    if (pick < 60) begin
      target      = int'($urandom_range(1 << 23, 0)) - (1 << 22);
      b.setpoint  = DATA_WIDTH'(target);
      b.measured  = DATA_WIDTH'(target + int'($urandom_range(1 << 17, 0)) - (1 << 16));
      b.step_time = ($urandom_range(19, 0) == 0) ? '0 : DT_W'($urandom_range(1 << 20, 1));
    end else if (pick < 85) begin
      b.setpoint  = DATA_WIDTH'($urandom);
      b.measured  = DATA_WIDTH'($urandom);
      b.step_time = DT_W'($urandom);
    end else begin
      b.setpoint = corner_value();
      b.measured = corner_value();
      case ($urandom_range(2, 0))
        0: b.step_time = '0;
        1: b.step_time = DT_W'(1);
        default: b.step_time = DT_MAX;
      endcase
    end
    return b;
  endfunction

  function automatic logic [GAIN_W-1:0] any_gain();
    case ($urandom_range(5, 0))
      0: return GAIN_MIN;
      1: return GAIN_MAX;
      2: return '0;
      3: return GAIN_W'($urandom);
      default: return GAIN_W'($urandom_range(32768, 0) - 16384);
    endcase
  endfunction

  function automatic logic [GAIN_W-1:0] gain_near_zero(int unsigned span);
    return GAIN_W'($urandom_range(2 * span, 0) - span);
  endfunction

  function automatic logic [LIMIT_W-1:0] any_limit();
    case ($urandom_range(3, 0))
      0: return '0;
      1: return LIMIT_MAX;
      2: return LIMIT_W'($urandom);
      default: return LIMIT_W'($urandom_range(1 << 24, 1));
    endcase
  endfunction

  // Offers one beat after a random gap and returns at the edge that takes it.
  // With no gap, valid simply stays high into the next beat.
  task automatic send_beat(input in_beat_t b);
    int gap;
    if (ramp_on || (beats_sent >= 60 && beats_sent < 110) || (beats_sent >= 300 && beats_sent < 340))
      gap = 0;
    else
      gap = $urandom_range(GAP_MAX, 0);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_beat  <= b;
    do @(posedge clk); while (!(in_valid && in_ready));
    tracker.take_sample(b);
    beats_sent++;
  endtask

  // Writes one register; the caller lowers the write enable after the last one.
  task automatic put_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] value);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= value;
    @(posedge clk);
    tracker.write_reg(idx, value);
  endtask

  // Gains go out with random bits above their width; the block must drop them.
  task automatic program_regs(input logic [GAIN_W-1:0] kp, input logic [GAIN_W-1:0] ki,
                              input logic [GAIN_W-1:0] kd, input logic [LIMIT_W-1:0] lim);
    put_reg(CFG_GAIN_PROP, {PAD_W'($urandom), kp});
    put_reg(CFG_GAIN_INTEG, {PAD_W'($urandom), ki});
    put_reg(CFG_GAIN_DERIV, {PAD_W'($urandom), kd});
    put_reg(CFG_EFFORT_LIMIT, CFG_DATA_W'(lim));
    cfg_we <= 1'b0;
  endtask

  // Stops offering and waits until every predicted drive beat has come back.
  // Every beat yields a result, so an empty queue means the block is idle.
  task automatic settle();
    in_valid <= 1'b0;
    while (tracker.outstanding() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Stimulus and final verdict.
  initial begin
    rst_n    <= 1'b0;
    in_valid <= 1'b0;
    in_beat  <= '0;
    cfg_we   <= 1'b0;
    cfg_idx  <= CFG_GAIN_PROP;
    cfg_data <= '0;
    ramp_on  <= 1'b0;
    beats_sent = 0;
    tracker = new();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed beats with the reset gains: an all-zero start, a zero time step
    // with the error held and with the error flipping sign (the derivative must
    // vanish), the largest errors of both signs and the smallest and largest steps.
    send_beat(make_beat('0, '0, '0));
    send_beat(make_beat(VAL_ONE, '0, DT_10MS));
    send_beat(make_beat(VAL_ONE, '0, '0));
    send_beat(make_beat('0, VAL_ONE, '0));
    send_beat(make_beat(VAL_MAX, VAL_MIN, DT_MAX));
    send_beat(make_beat(VAL_MIN, VAL_MAX, DT_W'(1)));
    send_beat(make_beat(VAL_MAX, VAL_MAX, DT_W'(1)));
    send_beat(make_beat(VAL_MIN, VAL_MIN, DT_MAX));
    send_beat(make_beat(-VAL_ONE, VAL_ONE, DT_MAX));

    // Extreme gains with the widest limit: a full error swing over one time
    // quantum drives the derivative term into its saturation.
    settle();
    program_regs(GAIN_MAX, GAIN_MIN, GAIN_MAX, LIMIT_MAX);
    send_beat(make_beat(VAL_MAX, VAL_MIN, DT_W'(1)));
    send_beat(make_beat(VAL_MIN, VAL_MAX, DT_W'(1)));
    send_beat(make_beat('0, '0, DT_MAX));
    send_beat(make_beat(DATA_WIDTH'(1), '0, DT_W'(1)));
    send_beat(make_beat('0, DATA_WIDTH'(1), DT_W'(2)));
    send_beat(make_beat(VAL_ONE, -VAL_ONE, DT_10MS));

    // Opposite extreme gains and a zero limit: every nonzero sum is clamped to zero.
    settle();
    program_regs(GAIN_MIN, GAIN_MAX, GAIN_MIN, '0);
    send_beat(make_beat('0, '0, '0));
    send_beat(make_beat(VAL_ONE, '0, DT_10MS));
    send_beat(make_beat(VAL_MIN, VAL_MAX, DT_MAX));
    send_beat(make_beat(VAL_MAX, VAL_MIN, '0));

    // Random phases. Even phases use small gains so that many results stay inside
    // the limit; odd phases draw the registers from their whole range and corners.
    for (int phase = 0; phase < 6; phase++) begin
      settle();
      if (phase % 2 == 0)
        program_regs(gain_near_zero(1 << 14), gain_near_zero(1 << 8), gain_near_zero(1 << 12),
                     ($urandom_range(1, 0) == 1) ? LIMIT_MAX : any_limit());
      else
        program_regs(any_gain(), any_gain(), any_gain(), any_limit());
      for (int n = 0; n < 100; n++)
        send_beat(random_beat());
    end

    // Push the integral hard upward with the largest error and step, back to back,
    // then pull it back down.
    settle();
    program_regs(GAIN_ONE, GAIN_W'(1), '0, LIMIT_MAX);
    ramp_on <= 1'b1;
    repeat (16) send_beat(make_beat(VAL_MAX, VAL_MIN, DT_MAX));
    repeat (3) send_beat(make_beat(VAL_MIN, VAL_MAX, DT_MAX));

    // Let the last result arrive, then watch for stray beats a while longer.
    settle();
    repeat (TAIL) @(posedge clk);
    if (tracker.mismatches == 0 && tracker.outstanding() == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

  // Result side: a random stall before each beat, stretches without stalls, and
  // two long hold-offs that back the block up into its input.
  initial begin
    int gap;
    out_ready <= 1'b0;
    beats_returned = 0;
    do @(posedge clk); while (!rst_n);
    forever begin
      if (ramp_on || (beats_returned >= 150 && beats_returned < 200) ||
          (beats_returned >= 450 && beats_returned < 500))
        gap = 0;
      else
        gap = $urandom_range(GAP_MAX, 0);
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!(out_valid && out_ready));
      tracker.compare_drive(out_beat);
      beats_returned++;
      if (beats_returned == 40 || beats_returned == 350) begin
        out_ready <= 1'b0;
        repeat (HOLD_OFF) @(posedge clk);
      end
    end
  end

  // Watchdog. Some 640 beats, plus the hold-offs, take under 2 ms at this clock; the limit
  // leaves about ten times that.
  initial begin
    #20_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule

[files.f]
rtl/pcc_pkg.sv
rtl/pcc_mul.sv
rtl/pcc_div.sv
rtl/pid_controller_with_clamp_top.sv
rtl/pcc_checker.sv
dv/testbench.sv
